[rtl/core/text_console_cursor_engine_assert.svh]
// Assertion macros shared by the console engine modules.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define TCCE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define TCCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tcce_pkg.sv]
// Shared types, sizes and codes for the text console cursor engine.
// No dependencies; every other file of the block but the assertion macro header imports this package.
`timescale 1ns / 1ps

package tcce_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_STOP   = 4;
	localparam int CELLS      = COLUMNS * ROWS;
	localparam int COPY_CELLS = COLUMNS * (ROWS - 1);

	// Derived widths
	localparam int CIDX_W = $clog2(COLUMNS);
	localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CELL_W = $clog2(CELLS);

	// Port field widths
	localparam int MODE_W      = 2;
	localparam int CHAR_W      = 8;
	localparam int INDEX_W     = 11;
	localparam int POS_W       = 11;
	localparam int CELL_DATA_W = 16;
	localparam int ATTR_W      = 8;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Reset and fill values
	localparam logic [ATTR_W-1:0]      ATTR_RESET  = 8'h07;
	localparam logic [CELL_DATA_W-1:0] BLANK_RESET = 16'h0720;
	localparam logic [CELL_DATA_W-1:0] BLANK_FILL  = 16'h0020;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// Classified operation
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_BS,
		OP_TAB,
		OP_CR,
		OP_LF,
		OP_READ,
		OP_CLEAR
	} op_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_READ,
		BK_SWEEP,
		BK_DONE
	} bk_state_t;

	// What a sweep over the frame store does
	typedef enum logic [1:0] {
		SW_INIT,
		SW_CLEAR,
		SW_SCROLL
	} sweep_t;

	// One classified command word
	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [CELL_W-1:0] addr;
		logic [CHAR_W-1:0] echo;
	} item_t;

	// Status from back to front
	typedef struct packed {
		logic init_busy;
	} bk_status_t;

	// Next tab stop for each column, built at elaboration
	typedef logic [COLUMNS-1:0][COL_W-1:0] tab_tbl_t;

	function automatic tab_tbl_t build_tab_tbl();
		tab_tbl_t t;
		for (int c = 0; c < COLUMNS; c++) begin
			t[c] = COL_W'((c / TAB_STOP + 1) * TAB_STOP);
		end
		return t;
	endfunction

	localparam tab_tbl_t TAB_NEXT = build_tab_tbl();

endpackage

[rtl/core/tcce_if.sv]
// Handshake channel interfaces of the console engine: command, result, config.
// Depends on tcce_pkg for field widths.
`timescale 1ns / 1ps

// Command channel
interface tcce_cmd_if import tcce_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [CHAR_W-1:0]   char_code;
	logic [INDEX_W-1:0]  cell_index;

	modport source (output valid, mode, char_code, cell_index, input ready);
	modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

// Result channel
interface tcce_rsp_if import tcce_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [POS_W-1:0]       cursor_position;
	logic [CELL_DATA_W-1:0] cell_value;
	logic [CHAR_W-1:0]      echo_code;

	modport source (output valid, cursor_position, cell_value, echo_code, input ready);
	modport sink   (input valid, cursor_position, cell_value, echo_code, output ready);
endinterface

// Attribute register write channel
interface tcce_cfg_if import tcce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] color_attribute;

	modport source (output valid, color_attribute, input ready);
	modport sink   (input valid, color_attribute, output ready);
endinterface

[rtl/core/tcce_front.sv]
// Front end: accepts command words, classifies them and queues them.
// Depends on tcce_pkg, tcce_if and the assertion macro header.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_assert.svh"

module tcce_front import tcce_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tcce_cmd_if.sink      cmd,
	input  bk_status_t    status,
	output logic          q_valid,
	output item_t         q_item,
	input  logic          q_pop
);

	item_t               fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	item_t               cls;
	logic                push;

	// Classify the incoming word
	always_comb begin
		cls      = '0;
		cls.op   = OP_NOP;
		cls.ch   = cmd.char_code;
		cls.addr = CELL_W'(cmd.cell_index);
		cls.echo = '0;
		unique case (cmd.mode)
			MODE_PUT: begin
				cls.echo = cmd.char_code;
				if (cmd.char_code >= CH_SPACE) begin
					cls.op = OP_PUT;
				end else begin
					unique case (cmd.char_code)
						CH_BS:   cls.op = OP_BS;
						CH_TAB:  cls.op = OP_TAB;
						CH_CR:   cls.op = OP_CR;
						CH_LF:   cls.op = OP_LF;
						default: cls.op = OP_NOP;
					endcase
				end
			end
			MODE_READ: begin
				// out-of-range reads report zero without touching the store
				cls.op = (32'(cmd.cell_index) < CELLS) ? OP_READ : OP_NOP;
			end
			MODE_CLEAR: cls.op = OP_CLEAR;
			default:    cls.op = OP_NOP;
		endcase
	end

	// Handshake
	assign cmd.ready = (count_q != QCNT_W'(QUEUE_DEPTH)) && !status.init_busy;
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = fifo_q[rd_ptr_q];

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	`TCCE_ASSERT_ALWAYS(a_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
	`TCCE_ASSERT_IMPLY(a_pop_nonempty, q_pop, count_q != '0, "pop from empty queue")
	`TCCE_ASSERT_IMPLY(a_init_empty, status.init_busy, count_q == '0, "word queued during init")
	`TCCE_ASSERT_NEXT(a_count_up, push && !q_pop, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

[rtl/core/tcce_back.sv]
// Back end: cursor, frame store, sweeps for init, clear and scroll, result register.
// Depends on tcce_pkg, tcce_if and the assertion macro header.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_assert.svh"

module tcce_back import tcce_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tcce_cfg_if.sink      cfg,
	tcce_rsp_if.source    rsp,
	input  logic          q_valid,
	input  item_t         q_item,
	output logic          q_pop,
	output bk_status_t    status
);

	bk_state_t               state_q, state_d;
	sweep_t                  sweep_q, sweep_d;
	item_t                   item_q, item_d;
	logic [CIDX_W-1:0]       col_q, col_d;
	logic [ROW_W-1:0]        row_q, row_d;
	logic [CELL_W-1:0]       lin_q, lin_d;
	logic [CELL_W-1:0]       scan_q, scan_d;
	logic [CELL_DATA_W-1:0]  cell_q, cell_d;
	logic [ATTR_W-1:0]       attr_q;

	// store write stage
	logic                    wr_en_s1, wr_en_d;
	logic [CELL_W-1:0]       wr_addr_s1, wr_addr_d;
	logic [CELL_DATA_W-1:0]  wr_data_s1, wr_data_d;
	logic                    wr_rd_s1, wr_rd_d;

	logic [CELL_DATA_W-1:0]  frame_mem_q [CELLS];
	logic [CELL_DATA_W-1:0]  rdata_q;
	logic [CELL_W-1:0]       rd_addr;

	logic                    out_valid_q;
	logic [POS_W-1:0]        out_pos_q;
	logic [CELL_DATA_W-1:0]  out_cell_q;
	logic [CHAR_W-1:0]       out_echo_q;
	logic                    load_out;
	logic                    newline;
	logic [COL_W-1:0]        tab_col;

	assign status.init_busy = (state_q == BK_SWEEP) && (sweep_q == SW_INIT);
	assign tab_col          = TAB_NEXT[col_q];

	// Sequencer: next state and datapath updates
	always_comb begin
		state_d   = state_q;
		sweep_d   = sweep_q;
		item_d    = item_q;
		col_d     = col_q;
		row_d     = row_q;
		lin_d     = lin_q;
		scan_d    = scan_q;
		cell_d    = cell_q;
		wr_en_d   = 1'b0;
		wr_addr_d = lin_q;
		wr_data_d = '0;
		wr_rd_d   = 1'b0;
		rd_addr   = item_q.addr;
		q_pop     = 1'b0;
		load_out  = 1'b0;
		newline   = 1'b0;

		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && (!out_valid_q || rsp.ready)) begin
					q_pop   = 1'b1;
					item_d  = q_item;
					cell_d  = '0;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_d = BK_DONE;
				unique case (item_q.op)
					OP_NOP: ;
					OP_PUT: begin
						wr_en_d   = 1'b1;
						wr_addr_d = lin_q;
						wr_data_d = {attr_q, item_q.ch};
						if (col_q == CIDX_W'(COLUMNS - 1)) begin
							newline = 1'b1;
						end else begin
							col_d = col_q + 1'b1;
							lin_d = lin_q + 1'b1;
						end
					end
					OP_BS: begin
						if (col_q != '0) begin
							col_d     = col_q - 1'b1;
							lin_d     = lin_q - 1'b1;
							wr_en_d   = 1'b1;
							wr_addr_d = lin_q - 1'b1;
							wr_data_d = {attr_q, CH_SPACE};
						end
					end
					OP_TAB: begin
						if (tab_col >= COL_W'(COLUMNS)) begin
							newline = 1'b1;
						end else begin
							col_d = CIDX_W'(tab_col);
							lin_d = lin_q - CELL_W'(col_q) + CELL_W'(tab_col);
						end
					end
					OP_CR: begin
						col_d = '0;
						lin_d = lin_q - CELL_W'(col_q);
					end
					OP_LF: newline = 1'b1;
					OP_READ: begin
						rd_addr = item_q.addr;
						state_d = BK_READ;
					end
					OP_CLEAR: begin
						col_d   = '0;
						row_d   = '0;
						lin_d   = '0;
						scan_d  = '0;
						sweep_d = SW_CLEAR;
						state_d = BK_SWEEP;
					end
					default: ;
				endcase
				// advance to the next row, scrolling past the last one
				if (newline) begin
					col_d = '0;
					if (row_q == ROW_W'(ROWS - 1)) begin
						lin_d   = CELL_W'(COPY_CELLS);
						scan_d  = '0;
						sweep_d = SW_SCROLL;
						state_d = BK_SWEEP;
					end else begin
						row_d = row_q + 1'b1;
						lin_d = lin_q - CELL_W'(col_q) + CELL_W'(COLUMNS);
					end
				end
			end
			BK_READ: begin
				cell_d  = rdata_q;
				state_d = BK_DONE;
			end
			BK_SWEEP: begin
				wr_en_d   = 1'b1;
				wr_addr_d = scan_q;
				unique case (sweep_q)
					SW_INIT:  wr_data_d = BLANK_RESET;
					SW_CLEAR: wr_data_d = {attr_q, CH_SPACE};
					SW_SCROLL: begin
						if (scan_q < CELL_W'(COPY_CELLS)) begin
							rd_addr = scan_q + CELL_W'(COLUMNS);
							wr_rd_d = 1'b1;
						end else begin
							wr_data_d = BLANK_FILL;
						end
					end
					default: wr_data_d = BLANK_RESET;
				endcase
				if (scan_q == CELL_W'(CELLS - 1)) begin
					state_d = (sweep_q == SW_INIT) ? BK_IDLE : BK_DONE;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			BK_DONE: begin
				load_out = 1'b1;
				state_d  = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: cursor, sweep, write stage, attribute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q  <= SW_INIT;
			scan_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
			lin_q    <= '0;
			wr_en_s1 <= 1'b0;
			attr_q   <= ATTR_RESET;
		end else begin
			sweep_q  <= sweep_d;
			scan_q   <= scan_d;
			col_q    <= col_d;
			row_q    <= row_d;
			lin_q    <= lin_d;
			wr_en_s1 <= wr_en_d;
			if (cfg.valid && cfg.ready) begin
				attr_q <= cfg.color_attribute;
			end
		end
	end

	assign cfg.ready = 1'b1;

	// Payload registers
	always_ff @(posedge clk) begin
		item_q     <= item_d;
		cell_q     <= cell_d;
		wr_addr_s1 <= wr_addr_d;
		wr_data_s1 <= wr_data_d;
		wr_rd_s1   <= wr_rd_d;
	end

	// Frame store: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			frame_mem_q[wr_addr_s1] <= wr_rd_s1 ? rdata_q : wr_data_s1;
		end
		rdata_q <= frame_mem_q[rd_addr];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pos_q  <= POS_W'(lin_q);
			out_cell_q <= cell_q;
			out_echo_q <= item_q.echo;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.cursor_position = out_pos_q;
	assign rsp.cell_value      = out_cell_q;
	assign rsp.echo_code       = out_echo_q;

	`TCCE_ASSERT_ALWAYS(a_cursor_bound, (col_q < CIDX_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)), "cursor off screen")
	`TCCE_ASSERT_ALWAYS(a_lin_match, 32'(lin_q) == 32'(row_q) * COLUMNS + 32'(col_q), "linear cursor out of step")
	`TCCE_ASSERT_IMPLY(a_pop_slot, q_pop, !out_valid_q || rsp.ready, "pop while result slot busy")
	`TCCE_ASSERT_NEXT(a_done_loads, state_q == BK_DONE, out_valid_q, "result not presented")

endmodule

[rtl/core/text_console_cursor_engine.sv]
// Console engine top over tcce_front and tcce_back; uses tcce_pkg and tcce_if.
// Put, BS, tab, CR, LF and ignored words pass the queue, then the IDLE, EXEC and DONE states;
// the back end takes one word at a time, the front queues up to two more. Reads add the READ
// state. A clear or a scroll adds a sweep over all 2000 cells of the frame store, bound by
// its single write port (one cell a cycle). After reset a clearing pass fills the store with
// 0x0720 while cmd.ready stays low; cursor homes and the attribute resets to 0x07.
`timescale 1ns / 1ps

module text_console_cursor_engine import tcce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tcce_cmd_if.sink   cmd,
	tcce_rsp_if.source rsp,
	tcce_cfg_if.sink   cfg
);

	logic       q_valid;
	item_t      q_item;
	logic       q_pop;
	bk_status_t status;

	// accept and classify
	tcce_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// execute against cursor and frame store
	tcce_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.rsp     (rsp),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.status  (status)
	);

endmodule

[verif/tb.sv]
// Self-checking testbench for text_console_cursor_engine: a directed set of codes, then
// random text, scroll, tab and readback phases under random send gaps and result
// stalls, then a full-rate phase. Depends on tcce_pkg and the tcce_if interfaces.
`timescale 1ns / 1ps

module tb;
	import tcce_pkg::*;

	// Codes the package does not name
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_CTRL_LO = 8'h01;
	localparam logic [CHAR_W-1:0] CH_CTRL_HI = 8'h1F;
	localparam logic [CHAR_W-1:0] CH_TOP     = 8'hFF;

	// Cycles with no accepted word before the run is declared hung
	localparam int QUIET_LIMIT = 40000;
	// Settle time after the last result
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [POS_W-1:0]       pos;
		logic [CELL_DATA_W-1:0] cval;
		logic [CHAR_W-1:0]      echo;
	} console_rsp_t;

	logic clk;
	logic arst_n;

	tcce_cmd_if cmd();
	tcce_rsp_if rsp();
	tcce_cfg_if cfg();

	text_console_cursor_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// Console shadow: screen, cursor and attribute
	logic [CELL_DATA_W-1:0] screen [0:CELLS-1];
	int unsigned            cur_col;
	int unsigned            cur_row;
	logic [ATTR_W-1:0]      attr_reg;

	console_rsp_t pending_rsp[$];
	int           fail_count;
	int           quiet_cycles;

	// Traffic shaping knobs
	bit sender_gaps;
	int rsp_stall_pct;
	int burst_left;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Console behavior for one command word; updates the shadow state
	function automatic console_rsp_t predict_console(logic [MODE_W-1:0] m,
			logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
		console_rsp_t r;
		r = '0;
		case (m)
			MODE_PUT: if (ch != CH_NUL) begin
				r.echo = ch;
				case (ch)
					CH_BS: if (cur_col > 0) begin
						cur_col--;
						screen[cur_row * COLUMNS + cur_col] = {attr_reg, CH_SPACE};
					end
					CH_TAB: cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
					CH_CR: cur_col = 0;
					CH_LF: begin
						cur_col = 0;
						cur_row++;
					end
					default: if (ch >= CH_SPACE) begin
						screen[cur_row * COLUMNS + cur_col] = {attr_reg, ch};
						cur_col++;
					end
				endcase
				// line wrap
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				// scroll up, last row gets attribute-0 blanks
				if (cur_row >= ROWS) begin
					cur_row = ROWS - 1;
					cur_col = 0;
					for (int i = 0; i < COPY_CELLS; i++)
						screen[i] = screen[i + COLUMNS];
					for (int i = COPY_CELLS; i < CELLS; i++)
						screen[i] = BLANK_FILL;
				end
			end
			MODE_READ: if (idx < CELLS) begin
				r.cval = screen[idx];
			end
			MODE_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = {attr_reg, CH_SPACE};
				cur_col = 0;
				cur_row = 0;
			end
			default: ;
		endcase
		r.pos = POS_W'(cur_row * COLUMNS + cur_col);
		return r;
	endfunction

	// Send one command word in bursts, with random gaps if sender_gaps is set; predict on accept
	task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (sender_gaps)
				gap = $urandom_range(1, 8);
		end
		burst_left--;
		if (gap != 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.mode       <= m;
		cmd.char_code  <= ch;
		cmd.cell_index <= idx;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		pending_rsp.push_back(predict_console(m, ch, idx));
	endtask

	// Drop valid and wait for every outstanding result plus a settle time
	task automatic drain_console;
		cmd.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		drain_console();
		cfg.valid           <= 1'b1;
		cfg.color_attribute <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		attr_reg = value;
	endtask

	// Character draw with weighted control codes (weights in percent)
	function automatic logic [CHAR_W-1:0] pick_char(int lf_w, int tab_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < lf_w)
			return CH_LF;
		r -= lf_w;
		if (r < tab_w)
			return CH_TAB;
		r -= tab_w;
		if (r < 4)
			return CH_BS;
		if (r < 6)
			return CH_CR;
		if (r < 9)
			return CHAR_W'($urandom_range(CH_CTRL_LO, CH_CTRL_HI));
		if (r < 10)
			return CH_NUL;
		return CHAR_W'($urandom_range(CH_SPACE, CH_TOP));
	endfunction

	// Random word stream; read_pct in percent, clear_pm in per mille
	task automatic run_text(int count, int lf_w, int tab_w, int read_pct, int clear_pm);
		int                 r;
		int unsigned        lin;
		int unsigned        back;
		logic [INDEX_W-1:0] idx;
		for (int n = 0; n < count; n++) begin
			idx = INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1));
			r = $urandom_range(0, 999);
			if (r < clear_pm) begin
				send_cmd(MODE_CLEAR, CHAR_W'($urandom), idx);
			end else if (r < clear_pm + 10) begin
				send_cmd(MODE_SPARE, CHAR_W'($urandom), idx);
			end else if ($urandom_range(0, 99) < read_pct) begin
				// cells near the cursor, anywhere on screen, or any 11-bit index, which may lie past the end
				r = $urandom_range(0, 99);
				lin = cur_row * COLUMNS + cur_col;
				back = $urandom_range(0, 12);
				if (r < 40)
					idx = INDEX_W'(lin >= back ? lin - back : 0);
				else if (r < 85)
					idx = INDEX_W'($urandom_range(0, CELLS - 1));
				send_cmd(MODE_READ, CHAR_W'($urandom), idx);
			end else begin
				send_cmd(MODE_PUT, pick_char(lf_w, tab_w), idx);
			end
		end
	endtask

	// Each code class at least once, under the reset attribute
	task automatic test_directed_codes;
		send_cmd(MODE_READ, CH_NUL, 11'd0);
		send_cmd(MODE_READ, CH_NUL, 11'h7FF);
		send_cmd(MODE_PUT, CH_NUL, 11'd0);
		send_cmd(MODE_PUT, 8'h41, 11'd0);
		send_cmd(MODE_PUT, CH_TOP, 11'h7FF);
		send_cmd(MODE_PUT, CH_SPACE, 11'd0);
		send_cmd(MODE_PUT, CH_BS, 11'd0);
		send_cmd(MODE_READ, CH_NUL, 11'd2);
		send_cmd(MODE_READ, CH_NUL, 11'd1);
		send_cmd(MODE_PUT, CH_TAB, 11'd0);
		send_cmd(MODE_PUT, CH_CTRL_LO, 11'd0);
		send_cmd(MODE_PUT, CH_CTRL_HI, 11'd0);
		send_cmd(MODE_PUT, CH_CR, 11'd0);
		send_cmd(MODE_PUT, CH_BS, 11'd0);
		send_cmd(MODE_PUT, CH_LF, 11'd0);
		send_cmd(MODE_SPARE, CH_TOP, 11'h7FF);
		send_cmd(MODE_PUT, 8'h80, 11'd0);
		send_cmd(MODE_READ, CH_NUL, 11'd80);
		send_cmd(MODE_READ, CH_NUL, INDEX_W'(CELLS - 1));
		send_cmd(MODE_READ, CH_NUL, INDEX_W'(CELLS));
		send_cmd(MODE_CLEAR, CH_NUL, 11'd0);
		send_cmd(MODE_READ, CH_NUL, 11'd0);
	endtask

	// Long printable runs wrap lines, attribute 0
	task automatic test_line_wrap;
		write_attribute(8'h00);
		run_text(250, 2, 2, 10, 2);
	endtask

	// Line-feed heavy text reaches the bottom row and scrolls, attribute 0xFF
	task automatic test_scroll;
		write_attribute(8'hFF);
		run_text(300, 12, 3, 15, 0);
	endtask

	// Tabs land on stops and wrap at the right edge
	task automatic test_tab_stops;
		write_attribute(ATTR_W'($urandom));
		run_text(250, 3, 25, 15, 2);
	endtask

	// Many reads and some clears; a fresh attribute between the two runs
	task automatic test_readback;
		write_attribute(8'h5A);
		run_text(125, 5, 5, 45, 15);
		write_attribute(ATTR_W'($urandom));
		run_text(125, 5, 5, 45, 15);
	endtask

	// Back-to-back words with the result side never stalling
	task automatic test_full_rate;
		write_attribute(8'hA5);
		sender_gaps   = 1'b0;
		rsp_stall_pct = 0;
		run_text(100, 6, 6, 20, 5);
	endtask

	initial begin
		arst_n              <= 1'b0;
		cmd.valid           <= 1'b0;
		cmd.mode            <= MODE_PUT;
		cmd.char_code       <= CH_NUL;
		cmd.cell_index      <= '0;
		cfg.valid           <= 1'b0;
		cfg.color_attribute <= ATTR_RESET;
		for (int i = 0; i < CELLS; i++)
			screen[i] = BLANK_RESET;
		cur_col       = 0;
		cur_row       = 0;
		attr_reg      = ATTR_RESET;
		fail_count    = 0;
		burst_left    = 0;
		stall_left    = 0;
		sender_gaps   = 1'b1;
		rsp_stall_pct = 25;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_codes();
		test_line_wrap();
		test_scroll();
		test_tab_stops();
		test_readback();
		test_full_rate();

		drain_console();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: random stalls with occasional long holds
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < 2) begin
			stall_left = $urandom_range(8, 40);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("result word with no command outstanding");
				fail_count++;
			end else begin
				if (rsp.cursor_position !== pending_rsp[0].pos) begin
					$error("cursor_position expected %0d got %0d",
						pending_rsp[0].pos, rsp.cursor_position);
					fail_count++;
				end
				if (rsp.cell_value !== pending_rsp[0].cval) begin
					$error("cell_value expected %h got %h",
						pending_rsp[0].cval, rsp.cell_value);
					fail_count++;
				end
				if (rsp.echo_code !== pending_rsp[0].echo) begin
					$error("echo_code expected %h got %h",
						pending_rsp[0].echo, rsp.echo_code);
					fail_count++;
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	// Watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/tcce_if.sv
rtl/core/tcce_front.sv
rtl/core/tcce_back.sv
rtl/core/text_console_cursor_engine.sv
verif/tb.sv
